// ===== hw/rtl/ptau_pkg.sv =====
// ----------------------------------------------------------------------------
// ptau_pkg
// shared types and constants of the ptp time arithmetic unit
// ----------------------------------------------------------------------------
package ptau_pkg;

    localparam logic [29:0]        NS_PER_SEC   = 30'd1000000000;
    localparam logic signed [31:0] NS_PER_SEC_S = 32'sd1000000000;
    localparam logic signed [30:0] NANO_MAX     = 31'sd999999999;
    localparam logic [9:0]         MS_PER_SEC   = 10'd1000;
    localparam logic [19:0]        NS_PER_MS    = 20'd1000000;
    // floor(x / 1000) == (x * MS_MAGIC) >> MS_SHIFT for every 32-bit x
    localparam logic [28:0]        MS_MAGIC     = 29'h10624DD3;
    localparam int                 MS_SHIFT     = 38;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef enum logic [2:0] {
        OP_ADD         = 3'd0,
        OP_SUB         = 3'd1,
        OP_NEGATE      = 3'd2,
        OP_DIVIDE      = 3'd3,
        OP_TO_NANOS    = 3'd4,
        OP_COMPARE     = 3'd5,
        OP_FROM_MILLIS = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        KIND_DONE,
        KIND_NORM,
        KIND_DIV,
        KIND_TO_NANOS,
        KIND_MILLIS
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MUL,
        ST_DIV2,
        ST_DIV3,
        ST_DIV_FIN,
        ST_TN,
        ST_MS_R,
        ST_MS_N
    } bk_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [63:0]        secs;
        logic signed [31:0] nanos;
        logic signed [30:0] an;
        logic signed [31:0] dv;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               dz;
    } entry_t;

endpackage

// ===== hw/rtl/ptau_front.sv =====
// ----------------------------------------------------------------------------
// ptau_front
// classifies a request and does the combinational part of its arithmetic
// ----------------------------------------------------------------------------
module ptau_front
(
    input  logic [2:0]          opcode,
    input  logic signed [63:0]  a_secs,
    input  logic signed [30:0]  a_nanos,
    input  logic signed [63:0]  b_secs,
    input  logic signed [30:0]  b_nanos,
    input  logic signed [31:0]  divisor,
    input  logic [31:0]         millis,
    output ptau_pkg::entry_t    entry
);

    function automatic logic signed [30:0] sat_nanos(input logic signed [30:0] n);
        logic signed [30:0] r;
        begin
            r = n;
            if (n > ptau_pkg::NANO_MAX)
            begin
                r = ptau_pkg::NANO_MAX;
            end
            else if (n < -ptau_pkg::NANO_MAX)
            begin
                r = -ptau_pkg::NANO_MAX;
            end
            return r;
        end
    endfunction

    logic signed [30:0] an;
    logic signed [30:0] bn;
    logic signed [31:0] an_w;
    logic signed [31:0] bn_w;

    assign an   = sat_nanos(a_nanos);
    assign bn   = sat_nanos(b_nanos);
    assign an_w = {an[30], an};
    assign bn_w = {bn[30], bn};

    always_comb
    begin
        entry       = '0;
        entry.kind  = ptau_pkg::KIND_DONE;
        entry.an    = an;
        entry.dv    = divisor;
        case (opcode)
            ptau_pkg::OP_ADD:
            begin
                entry.kind  = ptau_pkg::KIND_NORM;
                entry.secs  = a_secs + b_secs;
                entry.nanos = an_w + bn_w;
            end
            ptau_pkg::OP_SUB:
            begin
                entry.kind  = ptau_pkg::KIND_NORM;
                entry.secs  = a_secs - b_secs;
                entry.nanos = an_w - bn_w;
            end
            ptau_pkg::OP_NEGATE:
            begin
                entry.secs  = -a_secs;
                entry.nanos = -an_w;
            end
            ptau_pkg::OP_DIVIDE:
            begin
                if (divisor == 32'sd0)
                begin
                    entry.dz = 1'b1;
                end
                else if (divisor == -32'sd1)
                begin
                    entry.secs  = -a_secs;
                    entry.nanos = -an_w;
                end
                else
                begin
                    entry.kind = ptau_pkg::KIND_DIV;
                    entry.secs = a_secs;
                end
            end
            ptau_pkg::OP_TO_NANOS:
            begin
                entry.kind = ptau_pkg::KIND_TO_NANOS;
                entry.secs = a_secs;
            end
            ptau_pkg::OP_COMPARE:
            begin
                // lexicographic on (seconds, nanoseconds), both signed
                if (a_secs < b_secs)
                begin
                    entry.lt = 1'b1;
                end
                else if (a_secs > b_secs)
                begin
                    entry.gt = 1'b1;
                end
                else if (an < bn)
                begin
                    entry.lt = 1'b1;
                end
                else if (an > bn)
                begin
                    entry.gt = 1'b1;
                end
                else
                begin
                    entry.eq = 1'b1;
                end
            end
            ptau_pkg::OP_FROM_MILLIS:
            begin
                entry.kind = ptau_pkg::KIND_MILLIS;
                entry.secs = {32'd0, millis};
            end
            default:
            begin
                entry.kind = ptau_pkg::KIND_DONE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ptau_fifo.sv =====
// ----------------------------------------------------------------------------
// ptau_fifo
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module ptau_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptau_pkg::entry_t  wdata,
    input  logic              pop,
    output ptau_pkg::entry_t  rdata,
    output logic              full,
    output logic              empty
);

    ptau_pkg::entry_t                 mem_reg [ptau_pkg::FIFO_DEPTH];
    logic [ptau_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [ptau_pkg::FIFO_AW-1:0]     wr_ptr_next;
    logic [ptau_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [ptau_pkg::FIFO_AW-1:0]     rd_ptr_next;
    logic [ptau_pkg::FIFO_AW:0]       count_reg;
    logic [ptau_pkg::FIFO_AW:0]       count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == (ptau_pkg::FIFO_AW+1)'(ptau_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (ptau_pkg::FIFO_AW)'(do_push);
        rd_ptr_next = rd_ptr_reg + (ptau_pkg::FIFO_AW)'(do_pop);
        count_next  = count_reg + (ptau_pkg::FIFO_AW+1)'(do_push)
                                - (ptau_pkg::FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/ptau_back.sv =====
// ----------------------------------------------------------------------------
// ptau_back
// executes queued requests: normalize, shared bit-serial divider,
// split multiplies, and the output register
// ----------------------------------------------------------------------------
module ptau_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ptau_pkg::entry_t    head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [63:0]  res_secs,
    output logic signed [30:0]  res_nanos,
    output logic signed [63:0]  total_nanos,
    output logic                is_less,
    output logic                is_equal,
    output logic                is_greater,
    output logic                divide_by_zero
);

    ptau_pkg::bk_state_t state_reg;
    ptau_pkg::bk_state_t state_next;

    logic [5:0]  cnt_reg,  cnt_next;
    logic [63:0] quo_reg,  quo_next;
    logic [31:0] rem_reg,  rem_next;
    logic [31:0] dmag_reg, dmag_next;
    logic [63:0] q1_reg,   q1_next;
    logic [31:0] q2_reg,   q2_next;
    logic [30:0] an_reg,   an_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_a_reg, neg_a_next;
    logic [63:0] acc_reg,  acc_next;
    logic [63:0] secs_reg, secs_next;
    logic [31:0] ms_reg,   ms_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_secs_reg,  out_secs_next;
    logic [30:0] out_nanos_reg, out_nanos_next;
    logic [63:0] out_tn_reg,    out_tn_next;
    logic        out_lt_reg,    out_lt_next;
    logic        out_eq_reg,    out_eq_next;
    logic        out_gt_reg,    out_gt_next;
    logic        out_dz_reg,    out_dz_next;

    logic        out_free;
    logic        load;

    // divider step: one quotient bit per cycle
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [32:0] rem_sub;
    logic [31:0] rem_step;
    logic [63:0] quo_step;

    // normalize of a queued add or sub
    logic signed [31:0] nrm_n1, nrm_n2;
    logic [63:0]        nrm_s1, nrm_s2;

    // products and helpers
    logic [61:0] mul_r;
    logic [61:0] mul_lo;
    logic [61:0] mul_hi;
    logic [60:0] mul_ms;
    logic [31:0] ms_qk;
    logic [29:0] ms_ns;
    logic [63:0] secs_mag;
    logic [31:0] dv_mag;
    logic [30:0] an_mag;
    logic [31:0] q2_s;
    logic [31:0] q3_s;
    logic [31:0] fin_nanos;

    assign out_free = !out_valid_reg || !out_stall;

    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign rem_sub  = rem_sh - {1'b0, dmag_reg};
    assign div_ge   = (rem_sh >= {1'b0, dmag_reg});
    assign rem_step = div_ge ? rem_sub[31:0] : rem_sh[31:0];
    assign quo_step = {quo_reg[62:0], div_ge};

    assign secs_mag = head.secs[63] ? (64'd0 - head.secs) : head.secs;
    assign dv_mag   = head.dv[31] ? (32'd0 - head.dv) : head.dv;
    assign an_mag   = an_reg[30] ? (31'd0 - an_reg) : an_reg;

    assign mul_r    = rem_reg * ptau_pkg::NS_PER_SEC;
    assign mul_lo   = head.secs[31:0] * ptau_pkg::NS_PER_SEC;
    assign mul_hi   = secs_reg[63:32] * ptau_pkg::NS_PER_SEC;
    assign mul_ms   = head.secs[31:0] * ptau_pkg::MS_MAGIC;
    // quotient times 1000 from the quotient registered in acc_reg
    assign ms_qk    = {6'd0, acc_reg[63:ptau_pkg::MS_SHIFT]} * {22'd0, ptau_pkg::MS_PER_SEC};
    assign ms_ns    = rem_reg[9:0] * ptau_pkg::NS_PER_MS;

    assign q2_s      = neg_q_reg ? (32'd0 - q2_reg) : q2_reg;
    assign q3_s      = neg_a_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];
    assign fin_nanos = q2_s + q3_s;

    always_comb
    begin
        nrm_n1 = head.nanos;
        nrm_s1 = head.secs;
        if (head.nanos <= -ptau_pkg::NS_PER_SEC_S)
        begin
            nrm_n1 = head.nanos + ptau_pkg::NS_PER_SEC_S;
            nrm_s1 = head.secs - 64'd1;
        end
        else if (head.nanos >= ptau_pkg::NS_PER_SEC_S)
        begin
            nrm_n1 = head.nanos - ptau_pkg::NS_PER_SEC_S;
            nrm_s1 = head.secs + 64'd1;
        end
        nrm_n2 = nrm_n1;
        nrm_s2 = nrm_s1;
        // bring seconds and nanoseconds to one sign
        if (!nrm_s1[63] && (nrm_s1 != 64'd0) && (nrm_n1 < 32'sd0))
        begin
            nrm_s2 = nrm_s1 - 64'd1;
            nrm_n2 = nrm_n1 + ptau_pkg::NS_PER_SEC_S;
        end
        else if (nrm_s1[63] && (nrm_n1 > 32'sd0))
        begin
            nrm_s2 = nrm_s1 + 64'd1;
            nrm_n2 = nrm_n1 - ptau_pkg::NS_PER_SEC_S;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dmag_next      = dmag_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        an_next        = an_reg;
        neg_q_next     = neg_q_reg;
        neg_a_next     = neg_a_reg;
        acc_next       = acc_reg;
        secs_next      = secs_reg;
        ms_next        = ms_reg;
        pop            = 1'b0;
        load           = 1'b0;
        out_secs_next  = out_secs_reg;
        out_nanos_next = out_nanos_reg;
        out_tn_next    = out_tn_reg;
        out_lt_next    = out_lt_reg;
        out_eq_next    = out_eq_reg;
        out_gt_next    = out_gt_reg;
        out_dz_next    = out_dz_reg;

        case (state_reg)
            ptau_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.kind)
                        ptau_pkg::KIND_DONE:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                load           = 1'b1;
                                out_secs_next  = head.secs;
                                out_nanos_next = head.nanos[30:0];
                                out_tn_next    = '0;
                                out_lt_next    = head.lt;
                                out_eq_next    = head.eq;
                                out_gt_next    = head.gt;
                                out_dz_next    = head.dz;
                            end
                        end
                        ptau_pkg::KIND_NORM:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                load           = 1'b1;
                                out_secs_next  = nrm_s2;
                                out_nanos_next = nrm_n2[30:0];
                                out_tn_next    = '0;
                                out_lt_next    = 1'b0;
                                out_eq_next    = 1'b0;
                                out_gt_next    = 1'b0;
                                out_dz_next    = 1'b0;
                            end
                        end
                        ptau_pkg::KIND_DIV:
                        begin
                            pop        = 1'b1;
                            quo_next   = secs_mag;
                            rem_next   = '0;
                            cnt_next   = '0;
                            dmag_next  = dv_mag;
                            an_next    = head.an;
                            neg_q_next = head.secs[63] ^ head.dv[31];
                            neg_a_next = head.an[30] ^ head.dv[31];
                            state_next = ptau_pkg::ST_DIV1;
                        end
                        ptau_pkg::KIND_TO_NANOS:
                        begin
                            pop        = 1'b1;
                            secs_next  = head.secs;
                            acc_next   = {2'b00, mul_lo} + {{33{head.an[30]}}, head.an};
                            state_next = ptau_pkg::ST_TN;
                        end
                        ptau_pkg::KIND_MILLIS:
                        begin
                            pop        = 1'b1;
                            ms_next    = head.secs[31:0];
                            acc_next   = {3'b000, mul_ms};
                            state_next = ptau_pkg::ST_MS_R;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ptau_pkg::ST_DIV1:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    q1_next    = neg_q_reg ? (64'd0 - quo_step) : quo_step;
                    state_next = ptau_pkg::ST_MUL;
                end
            end
            ptau_pkg::ST_MUL:
            begin
                // remainder magnitude times one second in nanoseconds
                quo_next   = {2'b00, mul_r};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ptau_pkg::ST_DIV2;
            end
            ptau_pkg::ST_DIV2:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    q2_next    = quo_step[31:0];
                    quo_next   = {33'd0, an_mag};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ptau_pkg::ST_DIV3;
                end
            end
            ptau_pkg::ST_DIV3:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = ptau_pkg::ST_DIV_FIN;
                end
            end
            ptau_pkg::ST_DIV_FIN:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_secs_next  = q1_reg;
                    out_nanos_next = fin_nanos[30:0];
                    out_tn_next    = '0;
                    out_lt_next    = 1'b0;
                    out_eq_next    = 1'b0;
                    out_gt_next    = 1'b0;
                    out_dz_next    = 1'b0;
                    state_next     = ptau_pkg::ST_IDLE;
                end
            end
            ptau_pkg::ST_TN:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_secs_next  = '0;
                    out_nanos_next = '0;
                    out_tn_next    = acc_reg + {mul_hi[31:0], 32'd0};
                    out_lt_next    = 1'b0;
                    out_eq_next    = 1'b0;
                    out_gt_next    = 1'b0;
                    out_dz_next    = 1'b0;
                    state_next     = ptau_pkg::ST_IDLE;
                end
            end
            ptau_pkg::ST_MS_R:
            begin
                q1_next    = {38'd0, acc_reg[63:ptau_pkg::MS_SHIFT]};
                rem_next   = ms_reg - ms_qk;
                state_next = ptau_pkg::ST_MS_N;
            end
            ptau_pkg::ST_MS_N:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_secs_next  = q1_reg;
                    out_nanos_next = {1'b0, ms_ns};
                    out_tn_next    = '0;
                    out_lt_next    = 1'b0;
                    out_eq_next    = 1'b0;
                    out_gt_next    = 1'b0;
                    out_dz_next    = 1'b0;
                    state_next     = ptau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptau_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptau_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dmag_reg      <= dmag_next;
        q1_reg        <= q1_next;
        q2_reg        <= q2_next;
        an_reg        <= an_next;
        neg_q_reg     <= neg_q_next;
        neg_a_reg     <= neg_a_next;
        acc_reg       <= acc_next;
        secs_reg      <= secs_next;
        ms_reg        <= ms_next;
        out_secs_reg  <= out_secs_next;
        out_nanos_reg <= out_nanos_next;
        out_tn_reg    <= out_tn_next;
        out_lt_reg    <= out_lt_next;
        out_eq_reg    <= out_eq_next;
        out_gt_reg    <= out_gt_next;
        out_dz_reg    <= out_dz_next;
    end

    assign out_valid      = out_valid_reg;
    assign res_secs       = out_secs_reg;
    assign res_nanos      = out_nanos_reg;
    assign total_nanos    = out_tn_reg;
    assign is_less        = out_lt_reg;
    assign is_equal       = out_eq_reg;
    assign is_greater     = out_gt_reg;
    assign divide_by_zero = out_dz_reg;

endmodule

// ===== hw/rtl/ptp_time_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// ptp_time_arithmetic_unit
// signed seconds plus nanoseconds timestamp alu
// ----------------------------------------------------------------------------
// one request carries an opcode and both operands on the in channel
// (in_valid, in_stall); one result leaves on the out channel (out_valid,
// out_stall) for every request, in request order.
// the front classifies a request and does saturation, the raw add or
// subtract, negate and compare in the cycle it is accepted, writing a
// four-entry queue. the back takes the queue head.
// add, sub, negate, compare and zero or minus-one divide go straight to the
// output register; to nanos passes ST_TN, from millis ST_MS_R and ST_MS_N,
// and a divide three one-bit-per-cycle divider passes and a multiply step.
// throughput: one request per cycle for the short operations while out_stall
// is low; a divide holds the back for its whole run while the queue keeps
// accepting. reset clears the queue, the back state, the divider step count
// and out_valid; nothing else. a stalled result stays in the output register
// and the queue fills behind it; in_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module ptp_time_arithmetic_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic signed [63:0]  a_secs,
    input  logic signed [30:0]  a_nanos,
    input  logic signed [63:0]  b_secs,
    input  logic signed [30:0]  b_nanos,
    input  logic signed [31:0]  divisor,
    input  logic [31:0]         millis,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [63:0]  res_secs,
    output logic signed [30:0]  res_nanos,
    output logic signed [63:0]  total_nanos,
    output logic                is_less,
    output logic                is_equal,
    output logic                is_greater,
    output logic                divide_by_zero
);

    ptau_pkg::entry_t front_entry;
    ptau_pkg::entry_t fifo_head;
    logic             fifo_full;
    logic             fifo_empty;
    logic             fifo_pop;

    assign in_stall = fifo_full;

    ptau_front u_front
    (
        .opcode  (opcode),
        .a_secs  (a_secs),
        .a_nanos (a_nanos),
        .b_secs  (b_secs),
        .b_nanos (b_nanos),
        .divisor (divisor),
        .millis  (millis),
        .entry   (front_entry)
    );

    ptau_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_valid),
        .wdata (front_entry),
        .pop   (fifo_pop),
        .rdata (fifo_head),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    ptau_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (fifo_head),
        .head_valid     (!fifo_empty),
        .pop            (fifo_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .res_secs       (res_secs),
        .res_nanos      (res_nanos),
        .total_nanos    (total_nanos),
        .is_less        (is_less),
        .is_equal       (is_equal),
        .is_greater     (is_greater),
        .divide_by_zero (divide_by_zero)
    );

`ifndef SYNTHESIS
    a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({is_less, is_equal, is_greater}))
        else $error("more than one compare flag set");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_by_zero) |-> (res_secs == 64'sd0 && res_nanos == 31'sd0))
        else $error("divide by zero with nonzero result");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (is_less || is_equal || is_greater))
            |-> (total_nanos == 64'sd0 && res_secs == 64'sd0 && !divide_by_zero))
        else $error("compare result carries other fields");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("back popped an empty queue");
`endif

endmodule

// ===== test/tb_ptp_time_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ptp_time_arithmetic_unit
// self-checking bench for the seconds plus nanoseconds timestamp alu
// ----------------------------------------------------------------------------
// directed corner requests, then random requests under three idle mixes,
// a long output hold-off and a full drain. every accepted request is
// predicted in the bench and checked field by field, in order, against the
// results on the out channel.
// ----------------------------------------------------------------------------
module tb_ptp_time_arithmetic_unit;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 250;
    localparam longint NS_SEC     = 64'sd1000000000;
    localparam longint NANO_LIM   = 64'sd999999999;
    localparam longint SECS_MIN   = 64'sh8000000000000000;
    localparam longint SECS_MAX   = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic [2:0] OP_UNKNOWN = 3'd7;

    typedef struct {
        logic [63:0] secs;
        logic [30:0] nanos;
        logic [63:0] total;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
    } time_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic signed [63:0] a_secs;
    logic signed [30:0] a_nanos;
    logic signed [63:0] b_secs;
    logic signed [30:0] b_nanos;
    logic signed [31:0] divisor;
    logic [31:0]        millis;
    logic               out_valid;
    logic               out_stall;
    logic signed [63:0] res_secs;
    logic signed [30:0] res_nanos;
    logic signed [63:0] total_nanos;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               divide_by_zero;

    time_result_t pending_results[$];
    int error_count;
    int idle_pct;
    int stall_pct;
    int holdoff_cycles;
    int quiet_cycles;
    int requests_sent;
    int results_checked;
    int op_count[8];

    ptp_time_arithmetic_unit DUT (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint sat_nanos(logic signed [30:0] n);
        longint v;
        v = n;
        if (v > NANO_LIM)
            return NANO_LIM;
        if (v < -NANO_LIM)
            return -NANO_LIM;
        return v;
    endfunction

    // single carry or borrow, then bring the two parts to one sign
    function automatic void normalize_time(inout longint s, inout longint n);
        if (n <= -NS_SEC)
        begin
            n = n + NS_SEC;
            s = s - 1;
        end
        else if (n >= NS_SEC)
        begin
            n = n - NS_SEC;
            s = s + 1;
        end
        if (s > 0 && n < 0)
        begin
            s = s - 1;
            n = n + NS_SEC;
        end
        else if (s < 0 && n > 0)
        begin
            s = s + 1;
            n = n - NS_SEC;
        end
    endfunction

    function automatic time_result_t predict_time_op(logic [2:0] op,
                                                     longint as, logic signed [30:0] an_in,
                                                     longint bs, logic signed [30:0] bn_in,
                                                     logic signed [31:0] dv_in,
                                                     logic [31:0] ms);
        time_result_t r;
        longint an;
        longint bn;
        longint dv;
        longint rs;
        longint rn;
        longint rem;
        longint ms64;
        an = sat_nanos(an_in);
        bn = sat_nanos(bn_in);
        dv = dv_in;
        ms64 = {32'b0, ms};
        rs = 0;
        rn = 0;
        r.total = '0;
        r.lt = 1'b0;
        r.eq = 1'b0;
        r.gt = 1'b0;
        r.dz = 1'b0;
        case (op)
            ptau_pkg::OP_ADD:
            begin
                rs = as + bs;
                rn = an + bn;
                normalize_time(rs, rn);
            end
            ptau_pkg::OP_SUB:
            begin
                rs = as - bs;
                rn = an - bn;
                normalize_time(rs, rn);
            end
            ptau_pkg::OP_NEGATE:
            begin
                rs = -as;
                rn = -an;
            end
            ptau_pkg::OP_DIVIDE:
            begin
                if (dv == 0)
                    r.dz = 1'b1;
                else if (dv == -1)
                begin
                    rs = -as;
                    rn = -an;
                end
                else
                begin
                    rem = as % dv;
                    rn = an / dv + (NS_SEC * rem) / dv;
                    rs = as / dv;
                end
            end
            ptau_pkg::OP_TO_NANOS:
                r.total = as * NS_SEC + an;
            ptau_pkg::OP_COMPARE:
            begin
                if (as < bs)
                    r.lt = 1'b1;
                else if (as > bs)
                    r.gt = 1'b1;
                else if (an < bn)
                    r.lt = 1'b1;
                else if (an > bn)
                    r.gt = 1'b1;
                else
                    r.eq = 1'b1;
            end
            ptau_pkg::OP_FROM_MILLIS:
            begin
                rs = ms64 / 1000;
                rn = (ms64 % 1000) * 1000000;
            end
            default:
                ;
        endcase
        r.secs = rs;
        r.nanos = rn[30:0];
        return r;
    endfunction

    // idle at random, then drive one request at the falling edge and hold it until accepted
    task automatic send_request(logic [2:0] op, longint as, logic signed [30:0] an,
                                longint bs, logic signed [30:0] bn,
                                logic signed [31:0] dv, logic [31:0] ms);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        opcode = op;
        a_secs = as;
        a_nanos = an;
        b_secs = bs;
        b_nanos = bn;
        divisor = dv;
        millis = ms;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_time_op(op, as, an, bs, bn, dv, ms));
        requests_sent++;
        op_count[op]++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic longint rand_secs();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return $signed({$urandom, $urandom}) >>> $urandom_range(63);
            2: return longint'($urandom_range(200)) - 100;
            3: return ($urandom_range(1)) ? SECS_MAX - $urandom_range(2)
                                          : SECS_MIN + $urandom_range(2);
            default: return longint'($signed($urandom));
        endcase
    endfunction

    // nanoseconds with the same sign as secs, sometimes any 31-bit pattern
    function automatic logic signed [30:0] rand_nanos(longint s);
        longint n;
        if ($urandom_range(9) == 0)
            return 31'($urandom);
        case ($urandom_range(3))
            0: n = 999999999 - $urandom_range(3);
            1: n = $urandom_range(3);
            default: n = $urandom_range(999999999);
        endcase
        if (s < 0 || (s == 0 && $urandom_range(1)))
            n = -n;
        return 31'(n);
    endfunction

    function automatic logic signed [31:0] rand_divisor();
        case ($urandom_range(5))
            0: return 0;
            1: return -1;
            2: return $urandom;
            3: return $signed($urandom) >>> $urandom_range(31);
            default: return int'($urandom_range(20)) - 10;
        endcase
    endfunction

    task automatic send_random(int n);
        logic [2:0] op;
        longint as;
        longint bs;
        for (int i = 0; i < n; i++)
        begin
            op = ($urandom_range(49) == 0) ? OP_UNKNOWN : 3'($urandom_range(6));
            as = rand_secs();
            bs = ($urandom_range(3) == 0) ? as : rand_secs();
            send_request(op, as, rand_nanos(as), bs, rand_nanos(bs), rand_divisor(), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_request(ptau_pkg::OP_ADD, 1, 500000000, 2, 500000000, 0, 0);
        send_request(ptau_pkg::OP_ADD, 3, 999999999, 4, 999999999, 0, 0);
        send_request(ptau_pkg::OP_ADD, -1, -600000000, -2, -700000000, 0, 0);
        send_request(ptau_pkg::OP_ADD, 5, 100, -2, -300, 0, 0);
        send_request(ptau_pkg::OP_ADD, SECS_MAX, 999999999, 0, 1, 0, 0);
        send_request(ptau_pkg::OP_SUB, -3, -200, 2, 900000000, 0, 0);
        send_request(ptau_pkg::OP_SUB, SECS_MIN, 0, 1, 0, 0, 0);
        send_request(ptau_pkg::OP_NEGATE, SECS_MIN, -999999999, 0, 0, 0, 0);
        send_request(ptau_pkg::OP_DIVIDE, 7, 123, 0, 0, 0, 0);
        send_request(ptau_pkg::OP_DIVIDE, SECS_MIN, -5, 0, 0, -1, 0);
        send_request(ptau_pkg::OP_DIVIDE, -7, -500000000, 0, 0, 2, 0);
        send_request(ptau_pkg::OP_DIVIDE, SECS_MAX, 999999999, 0, 0, 32'sh80000000, 0);
        send_request(ptau_pkg::OP_DIVIDE, SECS_MIN, -999999999, 0, 0, 32'sh7FFFFFFF, 0);
        send_request(ptau_pkg::OP_TO_NANOS, -5, -1, 0, 0, 0, 0);
        send_request(ptau_pkg::OP_TO_NANOS, SECS_MAX, 999999999, 0, 0, 0, 0);
        send_request(ptau_pkg::OP_COMPARE, -1, -5, 1, 5, 0, 0);
        send_request(ptau_pkg::OP_COMPARE, 4, 10, 4, 10, 0, 0);
        send_request(ptau_pkg::OP_COMPARE, 4, 11, 4, 10, 0, 0);
        send_request(ptau_pkg::OP_COMPARE, 0, 31'sh3FFFFFFF, 0, 999999999, 0, 0);
        send_request(ptau_pkg::OP_FROM_MILLIS, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
        send_request(ptau_pkg::OP_FROM_MILLIS, 0, 0, 0, 0, 0, 999);
        // out-of-range nanos saturate
        send_request(ptau_pkg::OP_ADD, 0, 31'sh3FFFFFFF, 0, 31'sh40000000, 0, 0);
        send_request(OP_UNKNOWN, SECS_MAX, -1, SECS_MIN, 1, -1, 32'hFFFFFFFF);
        wait_drained();
    endtask

    task automatic test_random_mixes();
        idle_pct = 10;
        stall_pct = 53;
        send_random(350);
        idle_pct = 53;
        stall_pct = 10;
        send_random(350);
        idle_pct = 0;
        stall_pct = 0;
        send_random(350);
    endtask

    // hold the output off long enough for the queue to fill and stall input
    task automatic test_output_holdoff();
        idle_pct = 0;
        stall_pct = 20;
        @(negedge clk);
        holdoff_cycles = 300;
        send_random(100);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_random(50);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            holdoff_cycles = holdoff_cycles - 1;
            out_stall = 1'b1;
        end
        else
            out_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        time_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (res_secs !== exp_r.secs)
                begin
                    $error("res_secs expected %h got %h", exp_r.secs, res_secs);
                    error_count++;
                end
                if (res_nanos !== exp_r.nanos)
                begin
                    $error("res_nanos expected %h got %h", exp_r.nanos, res_nanos);
                    error_count++;
                end
                if (total_nanos !== exp_r.total)
                begin
                    $error("total_nanos expected %h got %h", exp_r.total, total_nanos);
                    error_count++;
                end
                if (is_less !== exp_r.lt)
                begin
                    $error("is_less expected %b got %b", exp_r.lt, is_less);
                    error_count++;
                end
                if (is_equal !== exp_r.eq)
                begin
                    $error("is_equal expected %b got %b", exp_r.eq, is_equal);
                    error_count++;
                end
                if (is_greater !== exp_r.gt)
                begin
                    $error("is_greater expected %b got %b", exp_r.gt, is_greater);
                    error_count++;
                end
                if (divide_by_zero !== exp_r.dz)
                begin
                    $error("divide_by_zero expected %b got %b", exp_r.dz, divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int settle;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = '0;
        a_secs = '0;
        a_nanos = '0;
        b_secs = '0;
        b_nanos = '0;
        divisor = '0;
        millis = '0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        holdoff_cycles = 0;
        requests_sent = 0;
        results_checked = 0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_mixes();
        test_output_holdoff();
        test_drain_pause();

        in_valid = 1'b0;
        wait_drained();
        settle = 0;
        while (settle < DRAIN_CYCLES)
        begin
            @(negedge clk);
            settle++;
        end
        $display("covered %0d requests, %0d results checked", requests_sent, results_checked);
        $display("add %0d sub %0d neg %0d div %0d tonanos %0d cmp %0d millis %0d bad %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5], op_count[6], op_count[7]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
